>>> rtl/core/pla_pkg.sv
// shared constants and types of the polyline length accumulator
`default_nettype none

package pla_pkg;

    localparam int COORD_WIDTH    = 24;
    localparam int LEN_WIDTH      = 48;
    localparam int COUNT_WIDTH    = 24;

    // squared step and the radicand of the root unit
    localparam int SQ_WIDTH       = 2 * COORD_WIDTH;
    localparam int RAD_WIDTH      = SQ_WIDTH + 1;
    localparam int SQRT_STEPS     = (RAD_WIDTH + 1) / 2;
    localparam int RAD_PAD_WIDTH  = 2 * SQRT_STEPS;
    localparam int ROOT_WIDTH     = SQRT_STEPS;
    localparam int REM_WIDTH      = ROOT_WIDTH + 2;
    localparam int STEP_CNT_WIDTH = $clog2(SQRT_STEPS + 1);

    // stream payload widths, rounded up to whole bytes
    localparam int IN_DATA_WIDTH  = ((2 * COORD_WIDTH + 7) / 8) * 8;
    localparam int OUT_DATA_WIDTH = ((2 * LEN_WIDTH + COUNT_WIDTH + 7) / 8) * 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQX,
        ST_SQY,
        ST_SUM,
        ST_ROOT,
        ST_ACC,
        ST_EMIT
    } seq_state_t;

endpackage

`default_nettype wire

>>> rtl/core/pla_sqrt.sv
// iterative floor square root, one root bit per cycle
`default_nettype none

module pla_sqrt (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             start,
    input  wire logic [pla_pkg::RAD_WIDTH-1:0]    radicand,
    output logic                                  busy,
    output logic      [pla_pkg::ROOT_WIDTH-1:0]   root
);

    logic [pla_pkg::RAD_PAD_WIDTH-1:0]  rad_reg;
    logic [pla_pkg::REM_WIDTH-1:0]      rem_reg;
    logic [pla_pkg::ROOT_WIDTH-1:0]     root_reg;
    logic [pla_pkg::STEP_CNT_WIDTH-1:0] cnt_reg;

    logic [pla_pkg::REM_WIDTH+1:0]      rem_shift;
    logic [pla_pkg::REM_WIDTH+1:0]      trial;
    logic                               fits;
    logic [pla_pkg::REM_WIDTH-1:0]      rem_next;
    logic [pla_pkg::ROOT_WIDTH-1:0]     root_next;

    always_comb begin
        rem_shift = {rem_reg, rad_reg[pla_pkg::RAD_PAD_WIDTH-1 -: 2]};
        trial     = (pla_pkg::REM_WIDTH+2)'({root_reg, 2'b01});
        fits      = (rem_shift >= trial);
        if (fits) begin
            rem_next  = pla_pkg::REM_WIDTH'(rem_shift - trial);
            root_next = {root_reg[pla_pkg::ROOT_WIDTH-2:0], 1'b1};
        end else begin
            rem_next  = pla_pkg::REM_WIDTH'(rem_shift);
            root_next = {root_reg[pla_pkg::ROOT_WIDTH-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= pla_pkg::STEP_CNT_WIDTH'(pla_pkg::SQRT_STEPS);
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= pla_pkg::RAD_PAD_WIDTH'(radicand);
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (cnt_reg != '0) begin
            rad_reg  <= {rad_reg[pla_pkg::RAD_PAD_WIDTH-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign busy = (cnt_reg != '0);
    assign root = root_reg;

endmodule

`default_nettype wire

>>> rtl/core/polyline_length_accumulator.sv
// top level: point stream in, chain length results out
//
// s_ channel: one point per transaction. s_tdata = {y_coord, x_coord}, signed Q16.8,
// s_tlast marks the last point of a chain, s_tuser marks the last chain of a set.
// m_ channel: one result per chain, on the transaction that carried s_tlast.
// m_tdata = {total_points, total_length, chain_length}, m_tlast = set_done.
// Each point that has a previous point goes through squaring dx, squaring dy
// and summing, then the square root (25 root bits and a finish step), then
// accumulate; the first point of a chain goes straight to accumulate. The point
// that ends a chain adds a result load step. The square root unit computes one
// root bit per cycle. After the last root bit come the finish step, accumulate
// and the result load, which waits for a free output register, then m_ is valid.
// The output register holds a finished result while the next point is accepted;
// a stalled receiver only holds the block when a second result is ready to load.
// Reset (aresetn low, synchronous) clears the previous point, all accumulators
// and any pending result.
`default_nettype none

module polyline_length_accumulator (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // x_coord [23:0], y_coord [47:24]
    input  wire logic [pla_pkg::IN_DATA_WIDTH-1:0]   s_tdata,
    input  wire logic                                s_tlast,
    // end_of_set [0]
    input  wire logic                                s_tuser,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // chain_length [47:0], total_length [95:48], total_points [119:96]
    output logic      [pla_pkg::OUT_DATA_WIDTH-1:0]  m_tdata,
    output logic                                     m_tlast
);

    localparam int CW = pla_pkg::COORD_WIDTH;
    localparam int LW = pla_pkg::LEN_WIDTH;
    localparam int NW = pla_pkg::COUNT_WIDTH;

    pla_pkg::seq_state_t state_reg, state_next;

    logic [CW-1:0] x_reg, y_reg, prev_x_reg, prev_y_reg;
    logic          eoc_reg, eos_reg, step_reg, have_prev_reg;
    logic [pla_pkg::SQ_WIDTH-1:0] sqx_reg, sqy_reg;
    logic [LW-1:0] chain_reg, total_reg;
    logic [NW-1:0] count_reg;

    logic [LW-1:0] out_chain_reg, out_total_reg;
    logic [NW-1:0] out_count_reg;
    logic          out_done_reg, m_valid_reg;

    logic          s_accept, out_free;
    logic          mul_sel_y, sqrt_start, out_load;
    logic          sqrt_busy;
    logic [pla_pkg::ROOT_WIDTH-1:0] sqrt_root;

    logic signed [CW:0] diff;
    logic [CW-1:0]      mag;
    logic [pla_pkg::SQ_WIDTH-1:0]  prod;
    logic [pla_pkg::RAD_WIDTH-1:0] radicand;
    logic [LW:0]        chain_sum, total_sum;
    logic [LW-1:0]      chain_next, total_next;
    logic [NW-1:0]      count_next;

    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // shared multiplier squares dx, then dy
    always_comb begin
        if (mul_sel_y) begin
            diff = {y_reg[CW-1], y_reg} - {prev_y_reg[CW-1], prev_y_reg};
        end else begin
            diff = {x_reg[CW-1], x_reg} - {prev_x_reg[CW-1], prev_x_reg};
        end
        mag  = diff[CW] ? CW'(-diff) : CW'(diff);
        prod = pla_pkg::SQ_WIDTH'(mag) * pla_pkg::SQ_WIDTH'(mag);
    end

    assign radicand = {1'b0, sqx_reg} + {1'b0, sqy_reg};

    pla_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (radicand),
        .busy     (sqrt_busy),
        .root     (sqrt_root)
    );

    // saturating accumulators
    always_comb begin
        chain_sum  = {1'b0, chain_reg} + (step_reg ? (LW+1)'(sqrt_root) : '0);
        chain_next = chain_sum[LW] ? '1 : chain_sum[LW-1:0];
        total_sum  = {1'b0, total_reg} + {1'b0, chain_reg};
        total_next = total_sum[LW] ? '1 : total_sum[LW-1:0];
        count_next = (count_reg == '1) ? count_reg : count_reg + 1'b1;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pla_pkg::ST_IDLE: begin
                if (s_accept) begin
                    state_next = have_prev_reg ? pla_pkg::ST_SQX : pla_pkg::ST_ACC;
                end
            end
            pla_pkg::ST_SQX:  state_next = pla_pkg::ST_SQY;
            pla_pkg::ST_SQY:  state_next = pla_pkg::ST_SUM;
            pla_pkg::ST_SUM:  state_next = pla_pkg::ST_ROOT;
            pla_pkg::ST_ROOT: begin
                if (!sqrt_busy) begin
                    state_next = pla_pkg::ST_ACC;
                end
            end
            pla_pkg::ST_ACC: begin
                state_next = eoc_reg ? pla_pkg::ST_EMIT : pla_pkg::ST_IDLE;
            end
            pla_pkg::ST_EMIT: begin
                if (out_free) begin
                    state_next = pla_pkg::ST_IDLE;
                end
            end
            default: state_next = pla_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready   = 1'b0;
        mul_sel_y  = 1'b0;
        sqrt_start = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            pla_pkg::ST_IDLE: s_tready   = 1'b1;
            pla_pkg::ST_SQY:  mul_sel_y  = 1'b1;
            pla_pkg::ST_SUM:  sqrt_start = 1'b1;
            pla_pkg::ST_EMIT: out_load   = out_free;
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pla_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // input capture and squared steps
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            x_reg    <= s_tdata[CW-1:0];
            y_reg    <= s_tdata[2*CW-1:CW];
            eoc_reg  <= s_tlast;
            eos_reg  <= s_tuser;
            step_reg <= have_prev_reg;
        end
        if (state_reg == pla_pkg::ST_SQX) begin
            sqx_reg <= prod;
        end
        if (state_reg == pla_pkg::ST_SQY) begin
            sqy_reg <= prod;
        end
    end

    // chain, set and point state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            have_prev_reg <= 1'b0;
            chain_reg     <= '0;
            total_reg     <= '0;
            count_reg     <= '0;
        end else if (state_reg == pla_pkg::ST_ACC) begin
            prev_x_reg    <= x_reg;
            prev_y_reg    <= y_reg;
            have_prev_reg <= 1'b1;
            chain_reg     <= chain_next;
            count_reg     <= count_next;
        end else if (out_load) begin
            have_prev_reg <= 1'b0;
            chain_reg     <= '0;
            total_reg     <= eos_reg ? '0 : total_next;
            if (eos_reg) begin
                count_reg <= '0;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_chain_reg <= chain_reg;
            out_total_reg <= total_next;
            out_count_reg <= count_reg;
            out_done_reg  <= eos_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = pla_pkg::OUT_DATA_WIDTH'({out_count_reg, out_total_reg, out_chain_reg});
    assign m_tlast  = out_done_reg;

endmodule

`default_nettype wire

>>> rtl/core/pla_checker.sv
// port-level checks of the polyline length accumulator, bound to the top level
`default_nettype none

module pla_checker (
    input wire logic                                aclk,
    input wire logic                                aresetn,
    input wire logic                                s_tvalid,
    input wire logic                                s_tready,
    input wire logic                                m_tvalid,
    input wire logic                                m_tready,
    input wire logic [pla_pkg::OUT_DATA_WIDTH-1:0]  m_tdata,
    input wire logic                                m_tlast
);

    localparam int LW = pla_pkg::LEN_WIDTH;
    localparam int NW = pla_pkg::COUNT_WIDTH;

    // no result survives reset
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // s_tready drops in the cycle after a point is accepted
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second point taken back to back");

    // set total includes the chain just finished
    a_total_ge_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[2*LW-1:LW] >= m_tdata[LW-1:0])
        else $error("total below chain length");

    // a result always counts at least its own point
    a_points_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[2*LW+NW-1:2*LW] != '0)
        else $error("result with zero points");

endmodule

bind polyline_length_accumulator pla_checker u_pla_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
